// File: hdl/u8dec_pkg.sv
`timescale 1ns / 1ps
// Package for the UTF-8 stream decoder: payload structs, byte class limits
// and the result bundle handed from the decoder to the output queue.
// No dependencies.
package u8dec_pkg;

  localparam int unsigned CodeW = 21;

  // Byte class upper bounds
  localparam logic [7:0] AsciiMax = 8'h7f;
  localparam logic [7:0] ContMax  = 8'hbf;
  localparam logic [7:0] Lead2Max = 8'hdf;
  localparam logic [7:0] Lead3Max = 8'hef;
  localparam logic [7:0] Lead4Max = 8'hf7;

  // Payload masks of the continuation and lead bytes
  localparam logic [7:0] ContMask  = 8'h3f;
  localparam logic [7:0] Lead2Mask = 8'h1f;
  localparam logic [7:0] Lead3Mask = 8'h0f;
  localparam logic [7:0] Lead4Mask = 8'h07;

  localparam logic [CodeW-1:0] ReplReset = 21'h00fffd;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } u8dec_in_t;

  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic             is_replacement;
    logic             last_of_run;
  } u8dec_out_t;

  // Up to two results produced by one byte
  typedef struct packed {
    logic [1:0] count;
    u8dec_out_t item0;
    u8dec_out_t item1;
  } u8dec_push_t;

endpackage

// File: hdl/u8dec_decode.sv
`timescale 1ns / 1ps
// Byte decoder: sequence state (pending count, accumulator) and the
// combinational decode of one byte into zero, one or two results.
// Depends on u8dec_pkg.
module u8dec_decode import u8dec_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  u8dec_in_t        item_i,
  input  logic [CodeW-1:0] repl_i,
  output u8dec_push_t      push_o
);

  logic [1:0]       pend_q, pend_d;
  logic [CodeW-1:0] accum_q, accum_d;
  u8dec_out_t       res0, res1;
  logic [1:0]       cnt;
  logic [7:0]       c;

  // Decode one byte against the current sequence state
  always_comb begin
    c       = item_i.in_byte;
    pend_d  = pend_q;
    accum_d = accum_q;
    cnt     = 2'd0;
    res0    = '{code_point: repl_i, is_replacement: 1'b1, last_of_run: 1'b0};
    res1    = '{code_point: repl_i, is_replacement: 1'b1, last_of_run: 1'b0};

    if (c <= AsciiMax) begin
      if (pend_q != 2'd0) begin
        // partial sequence broken by ASCII: replacement, then the byte
        res1   = '{code_point: {13'd0, c}, is_replacement: 1'b0, last_of_run: 1'b0};
        cnt    = 2'd2;
        pend_d = 2'd0;
      end else begin
        res0 = '{code_point: {13'd0, c}, is_replacement: 1'b0, last_of_run: 1'b0};
        cnt  = 2'd1;
      end
    end else if (c <= ContMax) begin
      if (pend_q != 2'd0) begin
        accum_d = {accum_q[CodeW-7:0], c[5:0] & ContMask[5:0]};
        pend_d  = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          res0 = '{code_point: accum_d, is_replacement: 1'b0, last_of_run: 1'b0};
          cnt  = 2'd1;
        end
      end else begin
        // stray continuation
        cnt = 2'd1;
      end
    end else if (c <= Lead2Max) begin
      pend_d  = 2'd1;
      accum_d = {13'd0, c & Lead2Mask};
    end else if (c <= Lead3Max) begin
      pend_d  = 2'd2;
      accum_d = {13'd0, c & Lead3Mask};
    end else if (c <= Lead4Max) begin
      pend_d  = 2'd3;
      accum_d = {13'd0, c & Lead4Mask};
    end else begin
      // invalid byte F8 and above
      cnt    = 2'd1;
      pend_d = 2'd0;
    end

    // end of string: flag a truncated sequence and return to idle
    if (item_i.end_of_string) begin
      if (pend_d != 2'd0) begin
        if (cnt == 2'd0) begin
          res0 = '{code_point: repl_i, is_replacement: 1'b1, last_of_run: 1'b0};
        end else begin
          res1 = '{code_point: repl_i, is_replacement: 1'b1, last_of_run: 1'b0};
        end
        cnt = cnt + 2'd1;
      end
      pend_d  = 2'd0;
      accum_d = '0;
    end

    res0.last_of_run = (cnt == 2'd1);
    res1.last_of_run = 1'b1;
    push_o = '{count: cnt, item0: res0, item1: res1};
  end

  // State update on each byte taken into decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 2'd0;
      accum_q <= '0;
    end else if (fire_i) begin
      pend_q  <= pend_d;
      accum_q <= accum_d;
    end
  end

endmodule

// File: hdl/u8dec_outq.sv
`timescale 1ns / 1ps
// Two-entry result queue: takes up to two decoder results per cycle if it has room,
// and presents one per unstalled cycle on the output channel. Depends on u8dec_pkg.
module u8dec_outq import u8dec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  input  u8dec_push_t push_i,
  output logic        push_ready_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output u8dec_out_t  out_data_o
);

  u8dec_out_t e0_q, e0_d, e1_q, e1_d;
  logic [1:0] cnt_q, cnt_d, cnt_ap, add;
  logic       pop;
  u8dec_out_t rem0;

  // Pop, room check and entry shuffle
  always_comb begin
    pop          = (cnt_q != 2'd0) && !out_stall_i;
    cnt_ap       = cnt_q - {1'b0, pop};
    push_ready_o = ({1'b0, cnt_ap} + {1'b0, push_i.count}) <= 3'd2;
    add          = push_valid_i ? push_i.count : 2'd0;
    rem0         = pop ? e1_q : e0_q;
    e0_d         = (cnt_ap != 2'd0) ? rem0 : push_i.item0;
    case (cnt_ap)
      2'd2:    e1_d = e1_q;
      2'd1:    e1_d = push_i.item0;
      default: e1_d = push_i.item1;
    endcase
    cnt_d = cnt_ap + add;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Entry payload, no reset
  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = e0_q;

endmodule

// File: hdl/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// UTF-8 stream decoder top: input register, byte decoder, result queue.
// A first result is valid once it has passed the input register and the queue.
// Throughput: one byte per cycle unless stalled; each second result of a byte
// can hold off the input later on, as the output moves one result per cycle.
// Reset clears sequence state, queue count, input valid; replacement code = 0xFFFD.
module utf8_stream_decoder import u8dec_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  u8dec_in_t        in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output u8dec_out_t       out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CodeW-1:0] cfg_data_i
);

  logic             in_valid_q, in_valid_d;
  u8dec_in_t        in_q;
  logic [CodeW-1:0] repl_q;
  logic             fire, push_ready, accept;
  u8dec_push_t      push;

  // Input register handshake
  assign fire        = in_valid_q && push_ready;
  assign in_stall_o  = in_valid_q && !push_ready;
  assign accept      = in_valid_i && !in_stall_o;
  assign in_valid_d  = accept || (in_valid_q && !fire);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      repl_q     <= ReplReset;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        repl_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  u8dec_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .repl_i (repl_q),
    .push_o (push)
  );

  u8dec_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fire),
    .push_i       (push),
    .push_ready_o (push_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// File: hdl/u8dec_checker.sv
`timescale 1ns / 1ps
// Port-level checker for utf8_stream_decoder, bound to the top level.
// Depends on u8dec_pkg.
module u8dec_checker import u8dec_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input u8dec_in_t        in_data_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input u8dec_out_t       out_data_o,
  input logic             cfg_valid_i,
  input logic             cfg_ready_o,
  input logic [CodeW-1:0] cfg_data_i
);

  logic [CodeW-1:0] repl_q;

  // Shadow of the replacement code register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= ReplReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      repl_q <= cfg_data_i;
    end
  end

  // Stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Stalled input byte stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input changed while stalled");

  // Input is only held off when results are waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Replacement results carry the configured code
  a_repl_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_replacement |-> out_data_o.code_point == repl_q)
    else $error("replacement result with wrong code");

  // No results and no input stall during reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("activity during reset");

endmodule

bind utf8_stream_decoder u8dec_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_data_i  (cfg_data_i)
);
